// ===== src/stereo_echo_delay_line_defines.svh =====
// Assertion macros used by the stereo echo delay line checker.
`ifndef STEREO_ECHO_DELAY_LINE_DEFINES_SVH
`define STEREO_ECHO_DELAY_LINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SEDL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SEDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/sedl_pkg.sv =====
// Package: types, constants and arithmetic helpers of the stereo echo delay line.
`timescale 1ns / 1ps
package sedl_pkg;

   localparam int MaxDelayWords = 16384;
   localparam int AddrWidth     = $clog2(MaxDelayWords);
   localparam int LenWidth      = AddrWidth + 1;

   localparam int DelayWordsWidth = 15;
   localparam int DecayGainWidth  = 16;
   localparam int ReadLeadWidth   = 14;
   localparam int CsrDataWidth    = 16;
   localparam int CsrIndexWidth   = 2;

   localparam logic [DelayWordsWidth-1:0] DelayWordsReset = DelayWordsWidth'(16384);
   localparam logic [DecayGainWidth-1:0]  DecayGainReset  = DecayGainWidth'(16384);
   localparam logic [ReadLeadWidth-1:0]   ReadLeadReset   = ReadLeadWidth'(512);

   localparam logic [CsrIndexWidth-1:0] CsrDelayWords = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrDecayGain  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrReadLead   = 2'd2;

   localparam int GainShift = 15;
   localparam int ProdWidth = 33;

   localparam int OutQueueDepth = 3;
   localparam int QPtrWidth     = 2;

   typedef logic [AddrWidth-1:0] sedl_addr_type;

   typedef struct packed {
      logic signed [15:0] high;
      logic signed [15:0] low;
   } sedl_word_type;

   typedef struct packed {
      logic          en;
      sedl_addr_type addr;
      sedl_word_type data;
   } sedl_mem_wr_type;

   function automatic logic signed [15:0] sedl_sat16(input logic signed [ProdWidth-1:0] v);
      logic signed [15:0] r;
      if (v > 33'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -33'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== src/stereo_echo_delay_line.sv =====
// Top level: stereo echo delay line with pointer control, read stage and mix stage.
// An accepted item passes the read stage register and the output queue before it is valid on rsp_.
// Throughput: one item per cycle unless req_stall, set by the single read and write ports of the delay memory.
// A word written in one cycle and read by the next item is forwarded around the memory.
// Reset: synchronous; the delay memory is then swept to zero with req_stall high.
// Configuration writes are taken every cycle, the sweep included.
`timescale 1ns / 1ps
module stereo_echo_delay_line (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_high,
   input  logic signed [15:0] req_sample_low,
   input  logic               req_has_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_out_high,
   output logic signed [15:0] rsp_out_low,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import sedl_pkg::*;

   logic [DelayWordsWidth-1:0] delay_words_ff;
   logic [DecayGainWidth-1:0]  decay_gain_ff;
   sedl_addr_type              rd_pos_ff;
   sedl_addr_type              rd_pos_in;
   sedl_addr_type              wr_pos_ff;
   sedl_addr_type              wr_pos_in;

   logic                       s1_valid_ff;
   sedl_word_type              s1_sample_ff;
   logic                       s1_has_ff;
   sedl_addr_type              s1_waddr_ff;
   logic                       fwd_ff;
   logic                       fwd_in;
   sedl_word_type              fwd_word_ff;

   logic [LenWidth-1:0]        len;
   sedl_addr_type              rd_eff;
   sedl_addr_type              wr_eff;
   logic                       accept;
   logic                       csr_write;
   logic                       clearing;
   sedl_word_type              mem_rd_data;
   sedl_word_type              echo_word;
   sedl_word_type              mix_result;
   sedl_word_type              mix_stored;
   sedl_word_type              q_head;
   sedl_mem_wr_type            mem_wr;
   logic [1:0]                 q_level;
   logic [2:0]                 occupancy;
   logic                       q_not_empty;
   logic                       pop;
   sedl_word_type              req_word;

   function automatic sedl_addr_type clip_pos(input sedl_addr_type p,
                                              input logic [LenWidth-1:0] l);
      sedl_addr_type r;
      r = ({1'b0, p} >= l) ? '0 : p;
      return r;
   endfunction

   function automatic sedl_addr_type step_pos(input sedl_addr_type p,
                                              input logic [LenWidth-1:0] l);
      logic [LenWidth-1:0] n;
      sedl_addr_type       r;
      n = {1'b0, p} + LenWidth'(1);
      r = (n >= l) ? '0 : n[AddrWidth-1:0];
      return r;
   endfunction

   // effective length: zero means one, oversize clamps to the memory depth
   always_comb begin
      if (delay_words_ff == '0) begin
         len = LenWidth'(1);
      end else if (int'(delay_words_ff) > MaxDelayWords) begin
         len = LenWidth'(MaxDelayWords);
      end else begin
         len = LenWidth'(delay_words_ff);
      end
   end

   assign occupancy = {1'b0, q_level} + {2'b0, s1_valid_ff};
   assign req_stall = clearing | (occupancy >= 3'(OutQueueDepth));
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   assign rd_eff = clip_pos(rd_pos_ff, len);
   assign wr_eff = clip_pos(wr_pos_ff, len);

   always_comb begin
      rd_pos_in = rd_pos_ff;
      wr_pos_in = wr_pos_ff;
      if (accept) begin
         rd_pos_in = step_pos(rd_eff, len);
         wr_pos_in = step_pos(wr_eff, len);
      end
      if (csr_write && csr_index == CsrReadLead) begin
         rd_pos_in = AddrWidth'(csr_data[ReadLeadWidth-1:0]);
         wr_pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_words_ff <= DelayWordsReset;
         decay_gain_ff  <= DecayGainReset;
         rd_pos_ff      <= AddrWidth'(ReadLeadReset);
         wr_pos_ff      <= '0;
      end else begin
         rd_pos_ff <= rd_pos_in;
         wr_pos_ff <= wr_pos_in;
         if (csr_write) begin
            unique case (csr_index)
               CsrDelayWords: delay_words_ff <= csr_data[DelayWordsWidth-1:0];
               CsrDecayGain:  decay_gain_ff  <= csr_data[DecayGainWidth-1:0];
               default: ;
            endcase
         end
      end
   end

   // the item in the mix stage writes at the same edge this read happens
   assign fwd_in = s1_valid_ff & (rd_eff == s1_waddr_ff);

   assign req_word.high = req_sample_high;
   assign req_word.low  = req_sample_low;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_word;
         s1_has_ff    <= req_has_sample;
         s1_waddr_ff  <= wr_eff;
         fwd_ff       <= fwd_in;
         fwd_word_ff  <= mix_stored;
      end
   end

   sedl_delay_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_eff),
      .rd_data  (mem_rd_data),
      .wr_req   (mem_wr),
      .clearing (clearing)
   );

   assign echo_word = fwd_ff ? fwd_word_ff : mem_rd_data;

   sedl_echo_mix u_mix (
      .echo       (echo_word),
      .sample     (s1_sample_ff),
      .has_sample (s1_has_ff),
      .decay_gain (decay_gain_ff),
      .result     (mix_result),
      .stored     (mix_stored)
   );

   assign mem_wr.en   = s1_valid_ff;
   assign mem_wr.addr = s1_waddr_ff;
   assign mem_wr.data = mix_stored;

   assign pop = q_not_empty & ~rsp_stall;

   sedl_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (mix_result),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head      (q_head),
      .level     (q_level)
   );

   assign rsp_valid    = q_not_empty;
   assign rsp_out_high = q_head.high;
   assign rsp_out_low  = q_head.low;

endmodule

// ===== src/sedl_delay_mem.sv =====
// Delay memory: single-port-write, registered-read word store with a clearing sweep after reset.
`timescale 1ns / 1ps
module sedl_delay_mem (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  sedl_pkg::sedl_addr_type  rd_addr,
   output sedl_pkg::sedl_word_type  rd_data,
   input  sedl_pkg::sedl_mem_wr_type wr_req,
   output logic                     clearing
);
   import sedl_pkg::*;

   sedl_word_type mem [MaxDelayWords];
   sedl_word_type rd_data_ff;
   logic          clr_busy_ff;
   logic          clr_busy_in;
   sedl_addr_type clr_addr_ff;
   sedl_addr_type clr_addr_in;
   logic          we;
   sedl_addr_type waddr;
   sedl_word_type wdata;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AddrWidth'(1);
         if (clr_addr_ff == AddrWidth'(MaxDelayWords - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // sweep owns the write port until every word is zero
   assign we    = clr_busy_ff | wr_req.en;
   assign waddr = clr_busy_ff ? clr_addr_ff : wr_req.addr;
   assign wdata = clr_busy_ff ? '0 : wr_req.data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clr_busy_ff;

endmodule

// ===== src/sedl_echo_mix.sv =====
// Echo mixer: scales the delayed word by the decay gain and mixes in the source item.
`timescale 1ns / 1ps
module sedl_echo_mix (
   input  sedl_pkg::sedl_word_type echo,
   input  sedl_pkg::sedl_word_type sample,
   input  logic                    has_sample,
   input  logic [15:0]             decay_gain,
   output sedl_pkg::sedl_word_type result,
   output sedl_pkg::sedl_word_type stored
);
   import sedl_pkg::*;

   logic signed [15:0]          echo_half   [2];
   logic signed [15:0]          sample_half [2];
   logic signed [15:0]          res_half    [2];
   logic signed [15:0]          sto_half    [2];
   logic signed [ProdWidth-1:0] gain_ext;

   assign echo_half[0]   = echo.high;
   assign echo_half[1]   = echo.low;
   assign sample_half[0] = sample.high;
   assign sample_half[1] = sample.low;
   assign gain_ext       = $signed({17'b0, decay_gain});

   for (genvar k = 0; k < 2; k++) begin : g_half
      logic signed [ProdWidth-1:0] prod;
      logic signed [ProdWidth-1:0] shifted;
      logic signed [15:0]          scaled;
      logic signed [ProdWidth-1:0] mixed_wide;
      logic signed [15:0]          mixed;
      logic signed [ProdWidth-1:0] fed_wide;

      // arithmetic shift gives the floor the echo path wants
      assign prod       = $signed({{17{echo_half[k][15]}}, echo_half[k]}) * gain_ext;
      assign shifted    = prod >>> GainShift;
      assign scaled     = sedl_sat16(shifted);
      assign mixed_wide = ProdWidth'(scaled) + ProdWidth'(sample_half[k]);
      assign mixed      = sedl_sat16(mixed_wide);
      assign fed_wide   = ProdWidth'(sample_half[k]) + ProdWidth'(mixed);

      assign res_half[k] = has_sample ? mixed : scaled;
      assign sto_half[k] = has_sample ? sedl_sat16(fed_wide) : scaled;
   end

   assign result.high = res_half[0];
   assign result.low  = res_half[1];
   assign stored.high = sto_half[0];
   assign stored.low  = sto_half[1];

endmodule

// ===== src/sedl_out_queue.sv =====
// Output queue: small register FIFO that holds results while the consumer stalls.
`timescale 1ns / 1ps
module sedl_out_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  sedl_pkg::sedl_word_type push_data,
   input  logic                    pop,
   output logic                    not_empty,
   output sedl_pkg::sedl_word_type head,
   output logic [1:0]              level
);
   import sedl_pkg::*;

   sedl_word_type          entries_ff [OutQueueDepth];
   logic [QPtrWidth-1:0]   wr_ptr_ff;
   logic [QPtrWidth-1:0]   wr_ptr_in;
   logic [QPtrWidth-1:0]   rd_ptr_ff;
   logic [QPtrWidth-1:0]   rd_ptr_in;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;

   function automatic logic [QPtrWidth-1:0] bump(input logic [QPtrWidth-1:0] p);
      logic [QPtrWidth-1:0] n;
      n = (p == QPtrWidth'(OutQueueDepth - 1)) ? '0 : p + QPtrWidth'(1);
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != 2'd0);
   assign head      = entries_ff[rd_ptr_ff];
   assign level     = count_ff;

endmodule

// ===== src/sedl_checker.sv =====
// Port-level checker for the stereo echo delay line, bound to the top level.
`timescale 1ns / 1ps
`include "stereo_echo_delay_line_defines.svh"
module sedl_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_out_high,
   input logic signed [15:0] rsp_out_low
);

   `SEDL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_high) && $stable(rsp_out_low), "stalled item changed")
   `SEDL_ASSERT_SAME(a_sweep_stall, clock, reset, $past(reset), req_stall, "item taken during memory sweep")
   `SEDL_ASSERT_SAME(a_no_early_rsp, clock, reset, $past(reset), !rsp_valid, "result shown straight after reset")
   `SEDL_ASSERT_SAME(a_latency, clock, reset, req_valid && !req_stall, ##2 rsp_valid, "accepted item missing two cycles on")

endmodule

bind stereo_echo_delay_line sedl_checker u_sedl_checker (.*);

// ===== test/tb_top.sv =====
// Testbench for the stereo echo delay line: directed and random items checked by an echo predictor.
`timescale 1ns / 1ps
module tb_top;
   import sedl_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CsrUnused = 2'd3;
   localparam int HoldOffCycles = 300;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_sample_high = '0;
   logic signed [15:0] req_sample_low = '0;
   logic               req_has_sample = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_high;
   logic signed [15:0] rsp_out_low;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [15:0]        csr_data = '0;

   // echo predictor state
   logic [31:0]                echo_mem [MaxDelayWords];
   int unsigned                rd_pos;
   int unsigned                wr_pos;
   logic [DelayWordsWidth-1:0] cfg_delay;
   logic [DecayGainWidth-1:0]  cfg_gain;
   logic [ReadLeadWidth-1:0]   cfg_lead;
   sedl_word_type              pending_outputs [$];

   int err_count = 0;
   bit offering = 1'b0;
   bit tx_idle_en = 1'b1;
   bit rx_idle_en = 1'b1;
   int hold_off_seq = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   stereo_echo_delay_line uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_high (req_sample_high),
      .req_sample_low  (req_sample_low),
      .req_has_sample  (req_has_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_high    (rsp_out_high),
      .rsp_out_low     (rsp_out_low),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // unsigned Q1.15 gain, floor by arithmetic shift
   function automatic logic signed [15:0] decay_echo(input logic signed [15:0] echo);
      longint prod;
      prod = longint'(echo) * longint'(cfg_gain);
      return clamp16(prod >>> GainShift);
   endfunction

   function automatic int unsigned echo_length();
      if (cfg_delay == 0) return 1;
      if (cfg_delay > MaxDelayWords) return MaxDelayWords;
      return cfg_delay;
   endfunction

   function automatic sedl_word_type next_echo_output(input logic signed [15:0] hi,
                                                      input logic signed [15:0] lo,
                                                      input logic has);
      int unsigned   len;
      sedl_word_type echo;
      sedl_word_type wet;
      sedl_word_type stored;
      len = echo_length();
      // stale positions restart at the bottom of the memory
      if (rd_pos >= len) rd_pos = 0;
      if (wr_pos >= len) wr_pos = 0;
      echo = echo_mem[rd_pos];
      wet.high = decay_echo(echo.high);
      wet.low = decay_echo(echo.low);
      stored = wet;
      if (has) begin
         wet.high = clamp16(longint'(wet.high) + longint'(hi));
         wet.low = clamp16(longint'(wet.low) + longint'(lo));
         stored.high = clamp16(longint'(hi) + longint'(wet.high));
         stored.low = clamp16(longint'(lo) + longint'(wet.low));
      end
      echo_mem[wr_pos] = stored;
      rd_pos = (rd_pos + 1 >= len) ? 0 : rd_pos + 1;
      wr_pos = (wr_pos + 1 >= len) ? 0 : wr_pos + 1;
      return wet;
   endfunction

   task automatic reset_echo_model();
      foreach (echo_mem[i]) echo_mem[i] = '0;
      cfg_delay = DelayWordsReset;
      cfg_gain = DecayGainReset;
      cfg_lead = ReadLeadReset;
      rd_pos = ReadLeadReset;
      wr_pos = 0;
   endtask

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 64) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic signed [15:0] hi, input logic signed [15:0] lo,
                            input logic has);
      if (tx_idle_en && $urandom_range(0, 4) == 0) begin
         if (offering) req_valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_high <= hi;
      req_sample_low <= lo;
      req_has_sample <= has;
      offering = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_outputs.push_back(next_echo_output(hi, lo, has));
   endtask

   // stops offering and waits until every output item is back
   task automatic drain_outputs();
      if (offering) req_valid <= 1'b0;
      offering = 1'b0;
      do @(posedge clock); while (pending_outputs.size() != 0);
   endtask

   // mask bits select delay, gain, read lead and the unused index, written in that order
   task automatic configure(input bit [3:0] mask, input logic [15:0] delay_val,
                            input logic [15:0] gain_val, input logic [15:0] lead_val);
      logic [CsrIndexWidth-1:0] idx [4];
      logic [15:0]              val [4];
      idx = '{CsrDelayWords, CsrDecayGain, CsrReadLead, CsrUnused};
      val = '{delay_val, gain_val, lead_val, 16'($urandom)};
      for (int i = 0; i < 4; i++) begin
         if (mask[i]) begin
            csr_valid <= 1'b1;
            csr_index <= idx[i];
            csr_data <= val[i];
            do @(posedge clock); while (!csr_ready);
            case (idx[i])
               CsrDelayWords: cfg_delay = val[i][DelayWordsWidth-1:0];
               CsrDecayGain: cfg_gain = val[i][DecayGainWidth-1:0];
               CsrReadLead: begin
                  cfg_lead = val[i][ReadLeadWidth-1:0];
                  rd_pos = cfg_lead;
                  wr_pos = 0;
               end
               default: ;
            endcase
         end
      end
      csr_valid <= 1'b0;
   endtask

   // receiver: random stall bursts, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_off_seq != hold_seen) begin
         hold_seen <= hold_off_seq;
         hold_left <= HoldOffCycles;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 7);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report_field(input string name, input logic signed [15:0] got,
                               input logic signed [15:0] want);
      if (got !== want) begin
         err_count++;
         if (err_count <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_output
      sedl_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outputs.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected output item: high %0d, low %0d", rsp_out_high, rsp_out_low);
         end else begin
            want = pending_outputs.pop_front();
            report_field("out_high", rsp_out_high, want.high);
            report_field("out_low", rsp_out_low, want.low);
         end
      end
   end

   // memory is zero after reset, so outputs follow the input on items with a sample and are zero otherwise
   task automatic test_reset_state();
      send_item(16'sh7fff, 16'sh8000, 1'b1);
      send_item(16'sh8000, 16'sh7fff, 1'b1);
      send_item(16'sh1234, -16'sd1, 1'b0);
      send_item(-16'sd1, 16'sd1, 1'b1);
      drain_outputs();
   endtask

   task automatic test_gain_extremes();
      configure(4'b0111, 16'd1, 16'd32768, 16'd0);
      send_item(16'sh7fff, 16'sh8000, 1'b1);
      send_item(16'sd0, 16'sd0, 1'b0);
      send_item(16'sd1, -16'sd1, 1'b1);
      drain_outputs();
      configure(4'b0010, 16'd0, 16'hffff, 16'd0);
      send_item(16'sd10, -16'sd10, 1'b0);
      drain_outputs();
      configure(4'b0010, 16'd0, 16'd0, 16'd0);
      send_item(16'sd5, -16'sd5, 1'b1);
      drain_outputs();
   endtask

   task automatic test_length_edges();
      configure(4'b1111, 16'd0, 16'd20000, 16'd0);
      send_item(pick_sample(), pick_sample(), 1'b1);
      send_item(pick_sample(), pick_sample(), 1'b0);
      drain_outputs();
      // oversized length saturates; read starts at the top word
      configure(4'b0101, 16'hffff, 16'd0, 16'd16383);
      send_item(16'sd100, -16'sd100, 1'b1);
      send_item(16'sd200, -16'sd200, 1'b1);
      drain_outputs();
      configure(4'b0101, 16'd8, 16'd0, 16'd5);
      send_item(pick_sample(), pick_sample(), 1'b1);
      send_item(pick_sample(), pick_sample(), 1'b1);
      drain_outputs();
      // shrink without realigning: read position is now past the end
      configure(4'b0001, 16'd4, 16'd0, 16'd0);
      send_item(pick_sample(), pick_sample(), 1'b1);
      send_item(pick_sample(), pick_sample(), 1'b0);
      send_item(pick_sample(), pick_sample(), 1'b1);
      drain_outputs();
   endtask

   // back-to-back items that read the word written just before, then with read and write at the same position
   task automatic test_read_lead_realign();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      configure(4'b0111, 16'd2, 16'd32768, 16'd1);
      repeat (4) send_item(pick_sample(), pick_sample(), 1'b1);
      drain_outputs();
      configure(4'b0101, 16'd16, 16'd0, 16'd0);
      repeat (3) send_item(pick_sample(), pick_sample(), 1'b1);
      drain_outputs();
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
   endtask

   task automatic test_output_hold_off();
      configure(4'b0111, 16'd5, 16'd30000, 16'd0);
      tx_idle_en = 1'b0;
      hold_off_seq++;
      repeat (24) send_item(pick_sample(), pick_sample(), $urandom_range(0, 3) != 0);
      drain_outputs();
      tx_idle_en = 1'b1;
   endtask

   task automatic test_random_streams(input int total);
      int          sent;
      int          phase_len;
      logic [15:0] dval;
      logic [15:0] gval;
      logic [15:0] lval;
      bit [3:0]    mask;
      sent = 0;
      while (sent < total) begin
         case ($urandom_range(0, 9))
            0: dval = 16'd0;
            1: dval = 16'($urandom_range(MaxDelayWords, 32767));
            2: dval = 16'(MaxDelayWords - $urandom_range(0, 3));
            3, 4: dval = 16'($urandom_range(1, 4));
            default: dval = 16'($urandom_range(1, 48));
         endcase
         case ($urandom_range(0, 5))
            0: gval = 16'd0;
            1: gval = 16'd32768;
            2: gval = 16'hffff;
            3: gval = 16'($urandom);
            default: gval = 16'($urandom_range(8192, 32768));
         endcase
         if ($urandom_range(0, 3) == 0)
            lval = 16'($urandom);
         else
            lval = 16'($urandom_range(0, (dval[14:0] > 16383) ? 16383 : dval[14:0]));
         // upper bits beyond the register width must be dropped
         if ($urandom_range(0, 7) == 0) dval[15] = 1'b1;
         mask = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(1, 15)) : 4'b0111;
         configure(mask, dval, gval, lval);
         tx_idle_en = $urandom_range(0, 3) != 0;
         rx_idle_en = $urandom_range(0, 3) != 0;
         phase_len = $urandom_range(60, 160);
         for (int i = 0; i < phase_len && sent < total; i++) begin
            send_item(pick_sample(), pick_sample(), $urandom_range(0, 4) != 0);
            sent++;
         end
         drain_outputs();
      end
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
   endtask

   task automatic test_final_streaming();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      configure(4'b0111, 16'd3, 16'd24000, 16'd2);
      repeat (100) send_item(pick_sample(), pick_sample(), $urandom_range(0, 5) != 0);
      drain_outputs();
   endtask

   initial begin
      reset_echo_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_gain_extremes();
      test_length_edges();
      test_read_lead_realign();
      test_output_hold_off();
      test_random_streams(1650);
      test_final_streaming();
      // catch any stray output item
      repeat (6) @(posedge clock);
      if (err_count == 0 && pending_outputs.size() == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
